FILE: design/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants and controller/datapath interface types for the
// next prime search block.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 16;
  localparam int FIELD_WIDTH         = 16;

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic next_div;
    logic next_cand;
    logic load_out;
    logic out_ovf;
  } cmd_t;

  typedef struct packed {
    logic sq_gt;
    logic div_last;
    logic rem_zero;
    logic cand_max;
  } status_t;

endpackage

FILE: design/nps_ctrl.sv
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer for the prime search: walks candidates and trial divisors and
// drives the handshakes of both channels.
// ----------------------------------------------------------------------------
module nps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  nps_pkg::status_t status,
  output nps_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TEST  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       ovf_flag;
  logic       ovf_flag_next;
  logic       out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    ovf_flag_next = ovf_flag;
    cmd           = '0;
    cmd.out_ovf   = ovf_flag;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (status.sq_gt) begin
          ovf_flag_next = 1'b0;
          state_next    = S_DONE;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.rem_zero) begin
          cmd.next_div = 1'b1;
          state_next   = S_TEST;
        end else if (status.cand_max) begin
          ovf_flag_next = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = S_TEST;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ovf_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ovf_flag <= ovf_flag_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/nps_datapath.sv
// ----------------------------------------------------------------------------
// nps_datapath
// Candidate, divisor and running square registers, a one-bit-per-cycle
// restoring remainder unit, and the result register.
// ----------------------------------------------------------------------------
module nps_datapath #(
  parameter int VALUE_WIDTH = nps_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  nps_pkg::cmd_t                   cmd,
  output nps_pkg::status_t                status,
  input  logic [nps_pkg::FIELD_WIDTH-1:0] start_value,
  output logic [nps_pkg::FIELD_WIDTH-1:0] prime_found,
  output logic                            overflow
);

  localparam int FW  = nps_pkg::FIELD_WIDTH;
  localparam int W   = VALUE_WIDTH;
  localparam int DW  = (W + 1) / 2 + 1;
  localparam int SQW = 2 * DW;
  localparam int BW  = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]      cand;
  logic [DW-1:0]     div;
  logic [SQW-1:0]    sq;
  logic [DW-1:0]     rem;
  logic [BW-1:0]     bit_idx;

  logic [W+FW-1:0]   in_ext;
  logic [W-1:0]      in_w;
  logic [W-1:0]      start_w;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              ge;
  logic [SQW-1:0]    cand_ext;
  logic [W+FW-1:0]   out_ext;

  assign in_ext   = {{W{1'b0}}, start_value};
  assign in_w     = in_ext[W-1:0];
  assign start_w  = (in_w < W'(2)) ? W'(2) : in_w;

  assign trial    = {rem, cand[bit_idx]};
  assign diff     = trial - {1'b0, div};
  assign ge       = (trial >= {1'b0, div});

  assign cand_ext = SQW'(cand);
  assign out_ext  = {{FW{1'b0}}, cand};

  assign status.sq_gt    = (sq > cand_ext);
  assign status.div_last = (bit_idx == '0);
  assign status.rem_zero = (rem == '0);
  assign status.cand_max = &cand;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand <= start_w;
      div  <= DW'(2);
      sq   <= SQW'(4);
    end else if (cmd.next_cand) begin
      cand <= cand + W'(1);
      div  <= DW'(2);
      sq   <= SQW'(4);
    end else if (cmd.next_div) begin
      div  <= div + DW'(1);
      sq   <= sq + SQW'({div, 1'b1});
    end
    if (cmd.start_div) begin
      rem     <= '0;
      bit_idx <= BW'(W - 1);
    end else if (cmd.div_step) begin
      rem     <= ge ? diff[DW-1:0] : trial[DW-1:0];
      bit_idx <= bit_idx - BW'(1);
    end
    if (cmd.load_out) begin
      prime_found <= cmd.out_ovf ? '0 : out_ext[FW-1:0];
      overflow    <= cmd.out_ovf;
    end
  end

endmodule

FILE: design/next_prime_search.sv
// ----------------------------------------------------------------------------
// next_prime_search
// Returns the smallest prime at or above start_value, found by trial
// division of successive candidates; flags overflow when none fits.
//
//   channel  signals                          direction
//   in       in_valid, in_stall, start_value  beat into the block
//   out      out_valid, out_stall,            beat out of the block
//            prime_found, overflow
//
// One item at a time. Each trial divisor passes a square test, one
// remainder bit per cycle in the bit-serial remainder unit, and a check.
// A result waits in the output register while the next beat is accepted.
// rst is synchronous, stalls the input and clears only control state;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module next_prime_search #(
  parameter int VALUE_WIDTH = nps_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nps_pkg::FIELD_WIDTH-1:0] start_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nps_pkg::FIELD_WIDTH-1:0] prime_found,
  output logic                            overflow
);

  nps_pkg::cmd_t    cmd;
  nps_pkg::status_t status;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  nps_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .start_value (start_value),
    .prime_found (prime_found),
    .overflow    (overflow)
  );

endmodule

FILE: design/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks for next_prime_search, bound to the top level.
// ----------------------------------------------------------------------------
module nps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [nps_pkg::FIELD_WIDTH-1:0] prime_found,
  input logic                            overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(prime_found) && $stable(overflow))
    else $error("stalled result beat changed");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> prime_found == '0)
    else $error("overflow result carries a nonzero value");

  a_prime_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow |-> (prime_found == 2) || (prime_found[0] && prime_found > 2))
    else $error("result is not a plausible prime");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before search finished");

endmodule

bind next_prime_search nps_checker u_nps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .prime_found (prime_found),
  .overflow    (overflow)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// next_prime_search testbench
// Sends start values over the input channel and checks every returned prime
// against a trial-division predictor. A directed set covers the field
// extremes, starts below two and the overflow range. Random starts follow,
// mostly small values because large ones are slow. Both sides idle in short
// random bursts, and the run ends quiet.
// ----------------------------------------------------------------------------

localparam int TB_VALUE_WIDTH = nps_pkg::VALUE_WIDTH_DEFAULT;
localparam int TB_FIELD_WIDTH = nps_pkg::FIELD_WIDTH;

typedef struct {
  logic [TB_FIELD_WIDTH-1:0] prime;
  logic                      ovf;
} prime_result_t;

class prime_scoreboard;
  prime_result_t expected_primes[$];
  int            failures;

  function prime_result_t smallest_prime_from(logic [TB_FIELD_WIDTH-1:0] start);
    longint unsigned limit;
    longint unsigned cand;
    longint unsigned d;
    bit              no_factor;
    prime_result_t   r;
    limit = (64'd1 << TB_VALUE_WIDTH) - 1;
    cand  = longint'(start) & limit;
    if (cand < 2) begin
      cand = 2;
    end
    r.prime = '0;
    r.ovf   = 1'b1;
    while (cand <= limit && r.ovf) begin
      no_factor = 1'b1;
      for (d = 2; d * d <= cand && no_factor; d++) begin
        if (cand % d == 0) begin
          no_factor = 1'b0;
        end
      end
      if (no_factor) begin
        r.prime = cand[TB_FIELD_WIDTH-1:0];
        r.ovf   = 1'b0;
      end else begin
        cand++;
      end
    end
    return r;
  endfunction

  function void note_start(logic [TB_FIELD_WIDTH-1:0] start);
    expected_primes.push_back(smallest_prime_from(start));
  endfunction

  function void check_result(logic [TB_FIELD_WIDTH-1:0] prime, logic ovf);
    prime_result_t exp_r;
    if (expected_primes.size() == 0) begin
      failures++;
      if (failures <= 10) begin
        $display("unexpected beat: prime_found=%0d overflow=%0b", prime, ovf);
      end
    end else begin
      exp_r = expected_primes.pop_front();
      if (prime !== exp_r.prime || ovf !== exp_r.ovf) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: prime_found exp %0d got %0d, overflow exp %0b got %0b",
                   exp_r.prime, prime, exp_r.ovf, ovf);
        end
      end
    end
  endfunction

  function int pending();
    return expected_primes.size();
  endfunction
endclass

module testbench;
  localparam int WATCHDOG_LIMIT = 1500000;
  localparam int TAIL_CYCLES    = 5000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [TB_FIELD_WIDTH-1:0] start_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [TB_FIELD_WIDTH-1:0] prime_found;
  logic                      overflow;

  prime_scoreboard sb;
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int              idle_cycles = 0;

  next_prime_search #(
    .VALUE_WIDTH(TB_VALUE_WIDTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_value(start_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .prime_found(prime_found),
    .overflow   (overflow)
  );

  always #5 clk = ~clk;

  // result side: check each beat, stall in short bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(prime_found, overflow);
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(1, 3) - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // no beat on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("next_prime_search regression: fail");
        $finish;
      end
    end
  end

  task automatic send_start(input logic [TB_FIELD_WIDTH-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_start(value);
  endtask

  task automatic wait_all_primes();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [TB_FIELD_WIDTH-1:0] random_start();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return TB_FIELD_WIDTH'($urandom_range(0, 1023));
    end else if (pick < 90) begin
      return TB_FIELD_WIDTH'($urandom_range(0, 16383));
    end else if (pick < 97) begin
      return TB_FIELD_WIDTH'($urandom_range(0, 65535));
    end
    // top of the range, where no prime may fit
    return TB_FIELD_WIDTH'($urandom_range(65480, 65535));
  endfunction

  initial begin
    logic [TB_FIELD_WIDTH-1:0] directed[$];
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd25, 16'd121,
                 16'd255, 16'd256, 16'd8191, 16'h5555, 16'hAAAA, 16'h00FF,
                 16'hFF00, 16'd32768, 16'd31398, 16'd65519, 16'd65520,
                 16'd65521, 16'd65522, 16'd65534, 16'd65535};
    foreach (directed[k]) begin
      send_start(directed[k]);
    end
    wait_all_primes();

    for (int chunk = 0; chunk < 12; chunk++) begin
      idle_on = (chunk < 10) ? ($urandom_range(0, 3) != 0) : 1'b0;
      for (int n = 0; n < 50; n++) begin
        send_start(random_start());
      end
      if (chunk == 5) begin
        wait_all_primes();
      end
    end

    wait_all_primes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("next_prime_search regression: pass");
    end else begin
      $display("next_prime_search regression: fail");
    end
    $finish;
  end
endmodule

FILE: next_prime_search.f
design/nps_pkg.sv
design/nps_ctrl.sv
design/nps_datapath.sv
design/next_prime_search.sv
design/nps_checker.sv
test/testbench.sv
